// ===== rtl/core/bpc_pkg.sv =====
// bpc_pkg: shared types, codes and constants for the button press classifier.
// No dependencies; used by bpc_eval, button_press_classifier_unit and the testbench.
package bpc_pkg;

    localparam int unsigned BUTTONS = 2;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_W   = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [CFG_W-1:0] LONG_TIME_RESET = 16'd500;

    // configuration register indexes
    localparam logic [0:0] REG_DEBOUNCE_TIME   = 1'b0;
    localparam logic [0:0] REG_LONG_PRESS_TIME = 1'b1;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        CODE_NONE  = 2'd0,
        CODE_SHORT = 2'd1,
        CODE_LONG  = 2'd2
    } t_code;

    typedef struct packed {
        logic               last_pressed;
        logic [STAMP_W-1:0] press_stamp;
        logic [STAMP_W-1:0] release_stamp;
        t_code              pending_code;
        logic               long_fired;
    } t_btn_state;

    localparam t_btn_state BTN_STATE_RESET = '{
        last_pressed:  1'b0,
        press_stamp:   '0,
        release_stamp: '0,
        pending_code:  CODE_NONE,
        long_fired:    1'b0
    };

endpackage

// ===== rtl/core/button_press_classifier_unit.sv =====
// button_press_classifier_unit: debounced short/long press classifier, top level.
// Depends on bpc_pkg and bpc_eval.
//
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/tready          tdata: button, level, now_ms; tuser: kind
//  m_axis    out   m_axis_tvalid/tready          tdata: press_code, held
//  cfg       in    i_cfg_we                      i_cfg_idx, i_cfg_wdata
//
// One word per cycle sustained while results are taken; an input register, then
// per-button evaluate and write-back into the result register.
// Per-button state is read and written in the same cycle, so back-to-back words
// on one button need no forwarding. Synchronous active-low reset clears the valid
// flags, button state and configuration. A stalled result holds the input register;
// s_axis_tready drops only when both stages are full.
module button_press_classifier_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,  // [0] button, [1] level, [33:2] now_ms
    input  logic                       s_axis_tuser,  // [0] kind
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [1:0] press_code, [2] held
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]  i_cfg_wdata
);

    logic [bpc_pkg::CFG_W-1:0]   r_debounce;
    logic [bpc_pkg::CFG_W-1:0]   r_long_time;

    logic                        r_s1_vld;
    logic                        r_s1_kind;
    logic                        r_s1_btn;
    logic                        r_s1_level;
    logic [bpc_pkg::STAMP_W-1:0] r_s1_now;

    logic                        r_out_vld;
    logic [1:0]                  r_out_code;
    logic                        r_out_held;

    bpc_pkg::t_btn_state         r_btn [bpc_pkg::BUTTONS];

    logic                        w_accept;
    logic                        w_adv;
    logic                        w_in_range;
    bpc_pkg::t_btn_state         w_cur;
    bpc_pkg::t_btn_state         n_btn;
    logic [1:0]                  n_code;
    logic                        n_held;

    assign w_adv         = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_range    = (32'(r_s1_btn) < 32'(bpc_pkg::BUTTONS));
    assign w_cur         = r_btn[r_s1_btn];

    bpc_eval u_eval (
        .i_state      (w_cur),
        .i_kind       (r_s1_kind),
        .i_level      (r_s1_level),
        .i_now_ms     (r_s1_now),
        .i_debounce   (r_debounce),
        .i_long_time  (r_long_time),
        .o_state      (n_btn),
        .o_press_code (n_code),
        .o_held       (n_held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= bpc_pkg::DEBOUNCE_RESET;
            r_long_time <= bpc_pkg::LONG_TIME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpc_pkg::REG_DEBOUNCE_TIME:   r_debounce  <= i_cfg_wdata;
                bpc_pkg::REG_LONG_PRESS_TIME: r_long_time <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind  <= s_axis_tuser;
            r_s1_btn   <= s_axis_tdata[0];
            r_s1_level <= s_axis_tdata[1];
            r_s1_now   <= s_axis_tdata[33:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpc_pkg::BUTTONS; i++) begin
                r_btn[i] <= bpc_pkg::BTN_STATE_RESET;
            end
        end else if (w_adv && w_in_range) begin
            r_btn[r_s1_btn] <= n_btn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_code <= w_in_range ? n_code : 2'(bpc_pkg::CODE_NONE);
            r_out_held <= w_in_range && n_held;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'b0, r_out_held, r_out_code};

endmodule

// ===== rtl/core/bpc_eval.sv =====
// bpc_eval: next-state and result logic for one button and one word.
// Depends on bpc_pkg.
module bpc_eval (
    input  bpc_pkg::t_btn_state          i_state,
    input  logic                         i_kind,
    input  logic                         i_level,
    input  logic [bpc_pkg::STAMP_W-1:0]  i_now_ms,
    input  logic [bpc_pkg::CFG_W-1:0]    i_debounce,
    input  logic [bpc_pkg::CFG_W-1:0]    i_long_time,
    output bpc_pkg::t_btn_state          o_state,
    output logic [1:0]                   o_press_code,
    output logic                         o_held
);

    logic                        w_pressed;
    logic [bpc_pkg::STAMP_W-1:0] w_dt_press;
    logic [bpc_pkg::STAMP_W-1:0] w_dt_rel;
    logic [bpc_pkg::STAMP_W-1:0] w_deb;
    logic [bpc_pkg::STAMP_W-1:0] w_long;
    logic                        w_free;

    assign w_pressed  = ~i_level;
    assign w_dt_press = i_now_ms - i_state.press_stamp;
    assign w_dt_rel   = i_now_ms - i_state.release_stamp;
    assign w_deb      = bpc_pkg::STAMP_W'(i_debounce);
    assign w_long     = bpc_pkg::STAMP_W'(i_long_time);
    assign w_free     = (i_state.pending_code == bpc_pkg::CODE_NONE) && !i_state.long_fired;

    always_comb begin
        o_state      = i_state;
        o_press_code = 2'(bpc_pkg::CODE_NONE);
        if (i_kind == bpc_pkg::KIND_READ) begin
            o_press_code         = 2'(i_state.pending_code);
            o_state.pending_code = bpc_pkg::CODE_NONE;
        end else begin
            if (w_pressed && !i_state.last_pressed) begin
                if (w_dt_rel > w_deb) begin
                    o_state.press_stamp = i_now_ms;
                    o_state.long_fired  = 1'b0;
                end
            end else if (!w_pressed && i_state.last_pressed) begin
                if (w_dt_press > w_deb) begin
                    o_state.release_stamp = i_now_ms;
                    if (w_free) begin
                        o_state.pending_code = (w_dt_press >= w_long) ? bpc_pkg::CODE_LONG
                                                                      : bpc_pkg::CODE_SHORT;
                    end
                    o_state.long_fired = 1'b0;
                end
            end else if (w_pressed && i_state.last_pressed) begin
                if ((w_dt_press >= w_long) && w_free) begin
                    o_state.pending_code = bpc_pkg::CODE_LONG;
                    o_state.long_fired   = 1'b1;
                end
            end
            o_state.last_pressed = w_pressed;
        end
        o_held = o_state.last_pressed;
    end

endmodule

// ===== rtl/core/bpc_checker.sv =====
// bpc_checker: port-level assertions for button_press_classifier_unit, bound below.
// Depends only on the top level's port names.
module bpc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tready,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [7:0]                 m_axis_tdata
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:3] == 5'd0))
        else $error("illegal result word");

    a_backpressure_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (.*);

// ===== sim/testbench.sv =====
// testbench: self-checking bench for button_press_classifier_unit.
// Depends on bpc_pkg and the RTL only; a table of directed words, then shaped random
// press/release sequences under five register settings, each checked by a local predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_WORDS = 245;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic            kind;
        logic            btn;
        logic            level;
        logic [31:0]     now_ms;
        logic            typed;
        bpc_pkg::t_code  code;
        logic            held;
    } t_stim_row;

    typedef struct packed {
        logic [1:0] code;
        logic       held;
    } t_press_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;   // [0] button, [1] level, [33:2] now_ms
    logic         s_axis_tuser;   // [0] kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;   // [1:0] press_code, [2] held
    logic         i_cfg_we;
    logic [0:0]   i_cfg_idx;
    logic [bpc_pkg::CFG_W-1:0] i_cfg_wdata;

    button_press_classifier_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor state: configuration copies, then one entry per button
    logic [bpc_pkg::CFG_W-1:0] debounce_cfg = bpc_pkg::DEBOUNCE_RESET;
    logic [bpc_pkg::CFG_W-1:0] long_ms      = bpc_pkg::LONG_TIME_RESET;
    logic           btn_down   [bpc_pkg::BUTTONS] = '{default: 1'b0};
    logic [31:0]    press_at   [bpc_pkg::BUTTONS] = '{default: 32'd0};
    logic [31:0]    release_at [bpc_pkg::BUTTONS] = '{default: 32'd0};
    bpc_pkg::t_code pending    [bpc_pkg::BUTTONS] = '{default: bpc_pkg::CODE_NONE};
    logic           long_done  [bpc_pkg::BUTTONS] = '{default: 1'b0};

    t_press_result awaited_results [$];

    logic           word_typed;
    bpc_pkg::t_code word_code;
    logic           word_held;
    int           tx_idle_pct   = 0;
    int           rx_stall_pct  = 0;
    int           hold_requests = 0;
    int           fail_count      = 0;
    int           words_sent      = 0;
    int           results_checked = 0;
    int           short_count     = 0;
    int           long_count      = 0;
    int           idle_cycles     = 0;

    t_stim_row directed_rows [25] = '{
        '{bpc_pkg::KIND_READ,   1'b0, 1'b1, 32'd0,         1'b1, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b1, 1'b1, 32'd0,         1'b1, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b1, 32'd0,         1'b1, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd100,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // bounce
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b1, 32'd110,       1'b1, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd115,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b1, 32'd215,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b0, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b0, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // too soon
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd225,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // long latch
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd615,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd700,       1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b0, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // no refire
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b0, 32'd2000,      1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b0, 1'b1, 32'd2100,      1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b0, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b0, 32'hFFFF_FFF0, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // wrap
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b1, 32'h0000_0010, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b0, 32'h0000_0100, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        // pending
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b1, 32'h0000_0400, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b1, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_SAMPLE, 1'b1, 1'b1, 32'h0000_0257, 1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b1, 1'b1, 32'd0,         1'b0, bpc_pkg::CODE_NONE, 1'b0},
        '{bpc_pkg::KIND_READ,   1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, bpc_pkg::CODE_NONE, 1'b0}
    };

    function automatic t_press_result classify_word(logic kind, logic btn, logic level,
                                                    logic [31:0] now_ms);
        t_press_result r;
        logic          pressed;
        logic          was;
        logic [31:0]   since_press;
        logic [31:0]   since_release;
        pressed       = ~level;
        was           = btn_down[btn];
        since_press   = now_ms - press_at[btn];
        since_release = now_ms - release_at[btn];
        r.code        = bpc_pkg::CODE_NONE;
        if (kind == bpc_pkg::KIND_SAMPLE) begin
            if (pressed && !was) begin
                if (since_release > 32'(debounce_cfg)) begin
                    press_at[btn]  = now_ms;
                    long_done[btn] = 1'b0;
                end
            end else if (!pressed && was) begin
                if (since_press > 32'(debounce_cfg)) begin
                    release_at[btn] = now_ms;
                    if (pending[btn] == bpc_pkg::CODE_NONE && !long_done[btn]) begin
                        pending[btn] = (since_press >= 32'(long_ms)) ? bpc_pkg::CODE_LONG
                                                                     : bpc_pkg::CODE_SHORT;
                    end
                    long_done[btn] = 1'b0;
                end
            end else if (pressed && was) begin
                if (since_press >= 32'(long_ms) && pending[btn] == bpc_pkg::CODE_NONE
                        && !long_done[btn]) begin
                    pending[btn]   = bpc_pkg::CODE_LONG;
                    long_done[btn] = 1'b1;
                end
            end
            btn_down[btn] = pressed;
        end else begin
            r.code       = pending[btn];
            pending[btn] = bpc_pkg::CODE_NONE;
        end
        r.held = btn_down[btn];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int holds_done;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= !($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_press_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected word: press_code %0d held %0d",
                           m_axis_tdata[1:0], m_axis_tdata[2]);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.code) begin
                        $error("press_code: expected %0d, actual %0d",
                               want.code, m_axis_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[2] !== want.held) begin
                        $error("held: expected %0d, actual %0d", want.held, m_axis_tdata[2]);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = classify_word(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
                                     s_axis_tdata[33:2]);
                if (word_typed) begin
                    want.code = word_code;
                    want.held = word_held;
                end
                if (want.code == bpc_pkg::CODE_SHORT) short_count++;
                if (want.code == bpc_pkg::CODE_LONG) long_count++;
                awaited_results.push_back(want);
                words_sent++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // entered and left just after a falling edge
    task automatic send_word(t_stim_row row);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.kind;
        s_axis_tdata  <= {6'd0, row.now_ms, row.level, row.btn};
        word_typed    <= row.typed;
        word_code     <= row.code;
        word_held     <= row.held;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic pick_word(output t_stim_row row);
        int unsigned  roll;
        logic [31:0]  offset;
        roll       = $urandom_range(99);
        row        = '0;
        row.btn    = 1'($urandom_range(1));
        row.kind   = bpc_pkg::KIND_SAMPLE;
        row.level  = 1'($urandom_range(1));
        row.now_ms = $urandom;
        if (roll < 15) begin
            row.kind = bpc_pkg::KIND_READ;
        end else if (roll >= 22) begin
            row.level = ($urandom_range(99) < 75) ? btn_down[row.btn] : ~btn_down[row.btn];
            case ($urandom_range(7))
                0: offset = 32'($urandom_range(debounce_cfg));
                1: offset = 32'(debounce_cfg);
                2: offset = 32'(debounce_cfg) + 32'd1;
                3: offset = 32'(long_ms) - 32'd1;
                4: offset = 32'(long_ms);
                5: offset = 32'(long_ms) + 32'd1;
                6: offset = 32'($urandom_range(2 * (int'(long_ms) + int'(debounce_cfg)) + 8));
                default: offset = $urandom;
            endcase
            // measure from the edge the block compares against
            if (row.level == 1'b0 && !btn_down[row.btn]) begin
                row.now_ms = release_at[row.btn] + offset;
            end else begin
                row.now_ms = press_at[row.btn] + offset;
            end
        end
    endtask

    task automatic run_random(int count);
        t_stim_row row;
        repeat (count) begin
            pick_word(row);
            send_word(row);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(logic [bpc_pkg::CFG_W-1:0] debounce,
                              logic [bpc_pkg::CFG_W-1:0] long_press);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= bpc_pkg::REG_DEBOUNCE_TIME;
        i_cfg_wdata <= debounce;
        @(posedge i_clk);
        debounce_cfg = debounce;
        @(negedge i_clk);
        i_cfg_idx   <= bpc_pkg::REG_LONG_PRESS_TIME;
        i_cfg_wdata <= long_press;
        @(posedge i_clk);
        long_ms = long_press;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bpc_pkg::KIND_SAMPLE;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = bpc_pkg::REG_DEBOUNCE_TIME;
        i_cfg_wdata   = '0;
        word_typed    = 1'b0;
        word_code     = bpc_pkg::CODE_NONE;
        word_held     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_word(directed_rows[i]);
        run_random(RANDOM_WORDS);
        settle();

        set_config('0, '0);
        tx_idle_pct = 81;
        run_random(RANDOM_WORDS);
        settle();

        set_config('1, '1);
        tx_idle_pct  = 0;
        rx_stall_pct = 81;
        run_random(RANDOM_WORDS);
        settle();

        set_config(bpc_pkg::CFG_W'($urandom_range(200)),
                   bpc_pkg::CFG_W'($urandom_range(2000)));
        tx_idle_pct  = 9;
        rx_stall_pct = 9;
        run_random(RANDOM_WORDS);
        settle();

        // long threshold below debounce; receiver holds off so the input backs up
        set_config(16'd300, 16'd100);
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_requests <= hold_requests + 1;
        run_random(RANDOM_WORDS);
        settle();
        repeat (8) @(negedge i_clk);

        $display("Ran %0d words (directed table, five register settings, idle/stall mixes);",
                 words_sent);
        $display("checked %0d results, including %0d short and %0d long presses.",
                 results_checked, short_count, long_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_eval.sv
rtl/core/button_press_classifier_unit.sv
rtl/core/bpc_checker.sv
sim/testbench.sv
